@@ sv/lrtf_pkg.sv @@
package lrtf_pkg;

  localparam int TIME_W = 16;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // operation codes on the input channel
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // one slot of the task table
  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] remaining;
  } entry_t;

  typedef struct packed {
    logic   en;
    entry_t data;
  } wr_req_t;

endpackage

@@ sv/lrtf_slot_mem.sv @@
module lrtf_slot_mem #(
  parameter int TASK_SLOTS = 8,
  parameter int IDX_W      = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lrtf_pkg::wr_req_t   wr,
  input  logic [IDX_W-1:0]    wr_addr,
  input  logic [IDX_W-1:0]    rd_addr,
  output lrtf_pkg::entry_t    rd_entry
);

  lrtf_pkg::entry_t        mem [TASK_SLOTS];
  logic [TASK_SLOTS-1:0]   vld_r;
  lrtf_pkg::entry_t        rd_entry_r;

  // track written entries; an unwritten entry reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // write the table
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr_addr] <= wr.data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (vld_r[rd_addr]) begin
      rd_entry_r <= mem[rd_addr];
    end else begin
      rd_entry_r <= '0;
    end
  end

  assign rd_entry = rd_entry_r;

endmodule

@@ sv/longest_remaining_time_first_scheduler.sv @@
// Longest-remaining-time-first scheduler over TASK_SLOTS task slots.
// Input channel (in_valid/in_ready): operation 0 loads arrival_time and
// burst_time into a slot and yields no result; operation 1 runs one tick.
// Result channel (out_valid/out_ready): one beat per tick with the slot
// that ran, the idle and finished flags, the time after the tick and the
// slot's remaining work.
// A tick scans the table, which sits in one memory with a single read
// port: the scan reads one slot per cycle, compares it against the running
// best, then writes the decremented entry back if a slot was found and
// registers the result. A new item is not accepted until the tick has
// finished. The result sits in an output register; a new item is accepted
// while it waits. If the receiver stalls, the next tick holds in its final
// step until the output register frees up.
// Reset clears the time counter and marks every slot empty at once.
module longest_remaining_time_first_scheduler #(
  parameter int TASK_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [2:0]  in_slot,
  input  logic [15:0] in_arrival_time,
  input  logic [15:0] in_burst_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_chosen_slot,
  output logic        out_idle,
  output logic        out_finished,
  output logic [15:0] out_time_after,
  output logic [15:0] out_remaining_after
);

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CNT_W = IDX_W + 1;
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TASK_SLOTS);

  lrtf_pkg::state_t   state_r, state_nxt;
  logic [CNT_W-1:0]   rd_cnt_r;
  logic               cmp_vld_r;
  logic [IDX_W-1:0]   cmp_idx_r;
  logic               found_r;
  logic [IDX_W-1:0]   best_idx_r;
  lrtf_pkg::entry_t   best_r;
  logic [15:0]        time_r;
  logic [15:0]        time_inc;

  logic               out_valid_r;
  logic [2:0]         out_slot_r;
  logic               out_idle_r;
  logic               out_fin_r;
  logic [15:0]        out_time_r;
  logic [15:0]        out_rem_r;

  logic               in_fire;
  logic               load_ok;
  logic               fin_fire;
  logic               scan_done;
  logic               eligible;
  logic [15:0]        rem_dec;

  lrtf_pkg::wr_req_t  wr;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W-1:0]   rd_addr;
  lrtf_pkg::entry_t   rd_entry;

  lrtf_slot_mem #(
    .TASK_SLOTS (TASK_SLOTS),
    .IDX_W      (IDX_W)
  ) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (wr),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  // handshake and datapath helpers
  assign in_fire   = in_valid && in_ready;
  assign load_ok   = {29'd0, in_slot} < 32'(TASK_SLOTS);
  assign fin_fire  = (state_r == lrtf_pkg::ST_FINISH) && (!out_valid_r || out_ready);
  assign scan_done = (rd_cnt_r == CNT_END) && !cmp_vld_r;
  assign time_inc  = (time_r == lrtf_pkg::TIME_MAX) ? time_r : time_r + 16'd1;
  assign rem_dec   = best_r.remaining - 16'd1;
  assign eligible  = (rd_entry.remaining != 16'd0) && (rd_entry.arrival <= time_r);
  assign rd_addr   = rd_cnt_r[IDX_W-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lrtf_pkg::ST_IDLE: begin
        if (in_fire && in_operation == lrtf_pkg::OP_TICK) begin
          state_nxt = lrtf_pkg::ST_SCAN;
        end
      end
      lrtf_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_nxt = lrtf_pkg::ST_FINISH;
        end
      end
      lrtf_pkg::ST_FINISH: begin
        if (fin_fire) begin
          state_nxt = lrtf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lrtf_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: input ready and table writes
  always_comb begin
    in_ready     = 1'b0;
    wr.en        = 1'b0;
    wr.data      = '0;
    wr_addr      = best_idx_r;
    unique case (state_r)
      lrtf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && in_operation == lrtf_pkg::OP_LOAD && load_ok) begin
          wr.en                = 1'b1;
          wr.data.arrival      = in_arrival_time;
          wr.data.remaining    = in_burst_time;
          wr_addr              = IDX_W'(in_slot);
        end
      end
      lrtf_pkg::ST_SCAN: begin
        in_ready = 1'b0;
      end
      lrtf_pkg::ST_FINISH: begin
        if (fin_fire && found_r) begin
          wr.en             = 1'b1;
          wr.data.arrival   = best_r.arrival;
          wr.data.remaining = rem_dec;
        end
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrtf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // advance the read pointer through the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r  <= '0;
      cmp_vld_r <= 1'b0;
    end else if (in_fire) begin
      rd_cnt_r  <= '0;
      cmp_vld_r <= 1'b0;
    end else if (state_r == lrtf_pkg::ST_SCAN && rd_cnt_r != CNT_END) begin
      rd_cnt_r  <= rd_cnt_r + CNT_W'(1);
      cmp_vld_r <= 1'b1;
    end else begin
      cmp_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= rd_addr;
  end

  // hold the running best; ties keep the earlier (lower) slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (in_fire) begin
      found_r <= 1'b0;
    end else if (cmp_vld_r && eligible &&
                 (!found_r || rd_entry.remaining > best_r.remaining)) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_vld_r && eligible && (!found_r || rd_entry.remaining > best_r.remaining)) begin
      best_idx_r <= cmp_idx_r;
      best_r     <= rd_entry;
    end
  end

  // advance time once per tick, saturating at the maximum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
    end else if (fin_fire) begin
      time_r <= time_inc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_time_r <= time_inc;
      out_idle_r <= !found_r;
      if (found_r) begin
        out_slot_r <= 3'(best_idx_r);
        out_fin_r  <= (rem_dec == 16'd0);
        out_rem_r  <= rem_dec;
      end else begin
        out_slot_r <= 3'd0;
        out_fin_r  <= 1'b0;
        out_rem_r  <= 16'd0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_chosen_slot     = out_slot_r;
  assign out_idle            = out_idle_r;
  assign out_finished        = out_fin_r;
  assign out_time_after      = out_time_r;
  assign out_remaining_after = out_rem_r;

`ifndef SYNTHESIS
  a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> time_r >= $past(time_r))
    else $error("time counter went backward");

  a_best_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == lrtf_pkg::ST_FINISH && found_r) |-> best_r.remaining != 16'd0)
    else $error("chosen slot has no remaining work");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == lrtf_pkg::ST_FINISH))
    else $error("result raised outside the finish step");

  a_tick_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_operation == lrtf_pkg::OP_TICK) |=> state_r == lrtf_pkg::ST_SCAN)
    else $error("accepted tick did not start a scan");
`endif

endmodule
